// ----- hdl/dtq_pkg.sv -----
// Package for the deadline timer queue: widths, action and status codes.
// Used by deadline_timer_queue_top; depends on nothing.
package dtq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_PRESCALE_EXP_DEF = 10;
	localparam int TICK_RESULT_CAP = 16;
	localparam int TIME_W = 64;
	localparam int TAG_W = 8;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_SCHED = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;
	localparam logic [1:0] ACT_READ = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TIMEDOUT = 3'd1;
	localparam logic [2:0] ST_STALE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_DUP = 3'd4;

	localparam logic REG_PRESCALE = 1'b0;
	localparam logic REG_REVISION = 1'b1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_SCANW = 8'b0000_0100,
		S_SHIFT = 8'b0000_1000,
		S_SHIFTW = 8'b0001_0000,
		S_PUT   = 8'b0010_0000,
		S_EXP   = 8'b0100_0000,
		S_EXPW  = 8'b1000_0000
	} state_t;

endpackage

// ----- hdl/deadline_timer_queue_top.sv -----
// Deadline timer queue top level: time counter, sorted deadline memory and sequencer.
// Depends on dtq_pkg.
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | action tag delay deadline request_revision
//  out     | output    | out_valid/out_stall | kind tag_res status time_value last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// A read, or a schedule rejected as stale or timed out, answers on the cycle after it
// is accepted. Schedule and cancel scan the table through the one-read memory port,
// entry by entry, then shift the entries that move one at a time. A tick reads the
// head and, for each expiry, walks the entries left behind the head down by one slot.
// Reset clears time, prescale count and entry count; the memory needs no clearing.
// A stalled result holds the sequencer; a new item is taken only when the previous
// one is fully done.
module deadline_timer_queue_top #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_PRESCALE_EXP = dtq_pkg::MAX_PRESCALE_EXP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  tag,
	input  logic [31:0] delay,
	input  logic [63:0] deadline,
	input  logic [7:0]  request_revision,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  tag_res,
	output logic [2:0]  status,
	output logic [63:0] time_value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = MAX_PRESCALE_EXP;
	localparam int EW = 4;

	// Entry memory: deadline and tag side by side.
	logic [71:0] mem [QUEUE_DEPTH];
	logic [71:0] rd_s1;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	logic [71:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[rd_addr];
	end

	logic [3:0] pexp_q;
	logic [7:0] rev_q;
	logic [63:0] time_q;
	logic [PW-1:0] pcnt_q;
	logic [CW-1:0] cnt_q;
	dtq_pkg::state_t st_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [1:0] act_q;
	logic [7:0] tag_q;
	logic [63:0] dl_q;
	logic found_q;
	logic [4:0] nexp_q;

	logic [63:0] rd_dl;
	logic [7:0] rd_tag;
	assign rd_dl = rd_s1[71:8];
	assign rd_tag = rd_s1[7:0];

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != dtq_pkg::S_IDLE) || (out_valid && out_stall);

	// Clamped exponent and prescale step.
	logic [EW-1:0] eff_e;
	logic [PW:0] period;
	logic [PW-1:0] pinc;
	assign eff_e = (pexp_q > EW'(MAX_PRESCALE_EXP)) ? EW'(MAX_PRESCALE_EXP) : pexp_q;
	assign period = (PW+1)'(1) << eff_e;
	assign pinc = pcnt_q + PW'(1);

	logic [63:0] sched_dl;
	assign sched_dl = (delay != 32'd0) ? time_q + {32'd0, delay} : deadline;

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	// The head just read expires on this tick and the per-tick cap is not reached.
	logic exp_more;
	assign exp_more = (cnt_q != '0) && (rd_dl <= time_q) &&
		(nexp_q != 5'(dtq_pkg::TICK_RESULT_CAP));

	always_comb begin
		rd_addr = idx_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_s1;
		unique case (st_q)
			dtq_pkg::S_SHIFT: begin
				// An insert moves the entry just below the current slot.
				if (act_q == dtq_pkg::ACT_SCHED) rd_addr = AW'(idx_q - CW'(1));
			end
			dtq_pkg::S_SHIFTW: begin
				// Entries slide up for insert or down for removal.
				wr_en = 1'b1;
				if (act_q == dtq_pkg::ACT_SCHED) wr_addr = AW'(idx_q + CW'(1));
				else wr_addr = AW'(idx_q - CW'(1));
			end
			dtq_pkg::S_PUT: begin
				wr_en = (act_q == dtq_pkg::ACT_SCHED);
				wr_addr = pos_q[AW-1:0];
				wr_data = {dl_q, tag_q};
			end
			dtq_pkg::S_EXP: rd_addr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pexp_q <= 4'd10;
			rev_q <= 8'd1;
			time_q <= '0;
			pcnt_q <= '0;
			cnt_q <= '0;
			st_q <= dtq_pkg::S_IDLE;
			out_valid <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			nexp_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == dtq_pkg::REG_PRESCALE) pexp_q <= cfg_data[3:0];
				else rev_q <= cfg_data;
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				dtq_pkg::S_IDLE: begin
					if (in_valid && !in_stall) begin
						act_q <= action;
						tag_q <= tag;
						idx_q <= '0;
						found_q <= 1'b0;
						nexp_q <= '0;
						kind <= 1'b0;
						tag_res <= tag;
						time_value <= '0;
						last <= 1'b1;
						unique case (action)
							dtq_pkg::ACT_TICK: begin
								if ((PW+1)'(pinc) >= period || pinc == '0) begin
									pcnt_q <= '0;
									time_q <= time_q + 64'd1;
								end else pcnt_q <= pinc;
								st_q <= dtq_pkg::S_EXP;
							end
							dtq_pkg::ACT_SCHED: begin
								dl_q <= sched_dl;
								pos_q <= cnt_q;
								if (request_revision != 8'd0 && request_revision != rev_q) begin
									status <= dtq_pkg::ST_STALE;
									out_valid <= 1'b1;
								end else if (sched_dl <= time_q) begin
									status <= dtq_pkg::ST_TIMEDOUT;
									out_valid <= 1'b1;
								end else st_q <= dtq_pkg::S_SCAN;
							end
							dtq_pkg::ACT_CANCEL: st_q <= dtq_pkg::S_SCAN;
							default: begin
								status <= dtq_pkg::ST_OK;
								time_value <= time_q;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				dtq_pkg::S_SCAN: begin
					if (idx_q == cnt_q) begin
						// Whole table seen.
						if (act_q == dtq_pkg::ACT_SCHED) begin
							if (found_q) begin
								status <= dtq_pkg::ST_DUP;
								out_valid <= 1'b1;
								st_q <= dtq_pkg::S_IDLE;
							end else if (cnt_q == CW'(QUEUE_DEPTH)) begin
								status <= dtq_pkg::ST_FULL;
								out_valid <= 1'b1;
								st_q <= dtq_pkg::S_IDLE;
							end else begin
								idx_q <= cnt_q;
								st_q <= dtq_pkg::S_SHIFT;
							end
						end else begin
							status <= dtq_pkg::ST_TIMEDOUT;
							out_valid <= 1'b1;
							st_q <= dtq_pkg::S_IDLE;
						end
					end else st_q <= dtq_pkg::S_SCANW;
				end
				dtq_pkg::S_SCANW: begin
					if (act_q == dtq_pkg::ACT_SCHED) begin
						if (rd_tag == tag_q) found_q <= 1'b1;
						if (rd_dl <= dl_q) pos_q <= cnt_q;
						else if (pos_q == cnt_q) pos_q <= idx_q;
						idx_q <= idx_q + CW'(1);
						st_q <= dtq_pkg::S_SCAN;
					end else if (rd_tag == tag_q) begin
						pos_q <= idx_q;
						idx_q <= idx_q + CW'(1);
						st_q <= dtq_pkg::S_SHIFT;
					end else begin
						idx_q <= idx_q + CW'(1);
						st_q <= dtq_pkg::S_SCAN;
					end
				end
				dtq_pkg::S_SHIFT: begin
					// Insert walks down from the top; removal walks up.
					if (act_q == dtq_pkg::ACT_SCHED) begin
						if (idx_q == pos_q) st_q <= dtq_pkg::S_PUT;
						else begin
							idx_q <= idx_q - CW'(1);
							st_q <= dtq_pkg::S_SHIFTW;
						end
					end else begin
						if (idx_q == cnt_q) st_q <= dtq_pkg::S_PUT;
						else st_q <= dtq_pkg::S_SHIFTW;
					end
				end
				dtq_pkg::S_SHIFTW: begin
					if (act_q != dtq_pkg::ACT_SCHED) idx_q <= idx_q + CW'(1);
					st_q <= dtq_pkg::S_SHIFT;
				end
				dtq_pkg::S_PUT: begin
					if (act_q == dtq_pkg::ACT_SCHED) cnt_q <= cnt_q + CW'(1);
					else cnt_q <= cnt_q - CW'(1);
					// A tick's removal walk goes back to read the new head instead of replying.
					if (act_q == dtq_pkg::ACT_TICK) st_q <= dtq_pkg::S_EXP;
					else begin
						status <= dtq_pkg::ST_OK;
						out_valid <= 1'b1;
						st_q <= dtq_pkg::S_IDLE;
					end
				end
				dtq_pkg::S_EXP: begin
					// Read the head entry at index zero.
					idx_q <= '0;
					st_q <= dtq_pkg::S_EXPW;
				end
				dtq_pkg::S_EXPW: begin
					if (found_q) begin
						// The held expiry goes out; it is final unless another one follows.
						out_valid <= 1'b1;
						last <= !exp_more;
						found_q <= 1'b0;
						if (!exp_more) st_q <= dtq_pkg::S_IDLE;
					end else if (out_free) begin
						if (exp_more) begin
							// Hold the head as the next expiry, then remove it.
							kind <= 1'b1;
							tag_res <= rd_tag;
							status <= dtq_pkg::ST_OK;
							time_value <= rd_dl;
							nexp_q <= nexp_q + 5'd1;
							act_q <= dtq_pkg::ACT_TICK;
							pos_q <= '0;
							idx_q <= CW'(1);
							found_q <= 1'b1;
							st_q <= dtq_pkg::S_SHIFT;
						end else st_q <= dtq_pkg::S_IDLE;
					end
				end
				default: st_q <= dtq_pkg::S_IDLE;
			endcase
		end
	end
endmodule
